/* rtl/lpps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lpps_pkg;

   // Field widths of the channels and the register port
   localparam int REQ_TYPE_W = 2;
   localparam int LED_IDX_W  = 2;
   localparam int SEQ_IDX_W  = 3;
   localparam int LEVELS_W   = 4;
   localparam int ACTIVE_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int MS_W       = 16;
   localparam int POS_W      = 2;
   localparam int UC_ADDR_W  = 4;

   // Defaults of the top level parameters
   localparam int LED_COUNT_DEF      = 4;
   localparam int SEQUENCE_COUNT_DEF = 6;
   localparam int MAX_STEPS_DEF      = 8;

   // Sequences held in the step table
   localparam int TABLE_SEQS = 6;

   typedef logic [REQ_TYPE_W-1:0] req_code_type;
   localparam req_code_type REQ_TICK = 2'd0;
   localparam req_code_type REQ_RUN  = 2'd1;
   localparam req_code_type REQ_STOP = 2'd2;

   typedef logic [CSR_IDX_W-1:0] csr_addr_type;
   localparam csr_addr_type CSR_ENABLE  = 2'd0;
   localparam csr_addr_type CSR_CHG_ON  = 2'd1;
   localparam csr_addr_type CSR_CHG_OFF = 2'd2;

   localparam logic             ENABLE_RST  = 1'b1;
   localparam logic [MS_W-1:0]  CHG_ON_RST  = 16'd200;
   localparam logic [MS_W-1:0]  CHG_OFF_RST = 16'd800;

   localparam logic [ACTIVE_W-1:0] ACTIVE_NONE = 3'd6;
   localparam logic [POS_W-1:0]    POS_STOPPED = 2'd3;

   typedef logic [SEQ_IDX_W-1:0] seq_code_type;
   localparam seq_code_type PAT_BATT_LOW  = 3'd0;
   localparam seq_code_type PAT_FULL      = 3'd1;
   localparam seq_code_type PAT_CHARGE    = 3'd2;
   localparam seq_code_type PAT_CAL_DONE  = 3'd3;
   localparam seq_code_type PAT_HEARTBEAT = 3'd4;
   localparam seq_code_type PAT_LINK      = 3'd5;

   localparam logic [MS_W-1:0] MS_STEADY    = 16'd1000;
   localparam logic [MS_W-1:0] MS_ALIVE_ON  = 16'd50;
   localparam logic [MS_W-1:0] MS_ALIVE_OFF = 16'd1950;
   localparam logic [MS_W-1:0] MS_LINKUP    = 16'd100;

   typedef enum logic [1:0] {
      KIND_WAIT,
      KIND_CHG_ON,
      KIND_CHG_OFF,
      KIND_LOOP
   } step_kind_type;

   typedef struct packed {
      step_kind_type   kind;
      logic            level;
      logic [MS_W-1:0] ms;
   } step_type;

   // Blink step table, indexed by sequence and position
   function automatic step_type step_lookup(input logic [SEQ_IDX_W-1:0] seq,
                                            input logic [POS_W-1:0] pos);
      step_type st;
      st = '{kind: KIND_LOOP, level: 1'b0, ms: '0};
      case (seq)
         PAT_BATT_LOW, PAT_FULL, PAT_CAL_DONE: begin
            if (pos == 2'd0) st = '{kind: KIND_WAIT, level: 1'b1, ms: MS_STEADY};
         end
         PAT_CHARGE: begin
            if (pos == 2'd0) st = '{kind: KIND_CHG_ON, level: 1'b1, ms: '0};
            else if (pos == 2'd1) st = '{kind: KIND_CHG_OFF, level: 1'b0, ms: '0};
         end
         PAT_HEARTBEAT: begin
            if (pos == 2'd0) st = '{kind: KIND_WAIT, level: 1'b1, ms: MS_ALIVE_ON};
            else if (pos == 2'd1) st = '{kind: KIND_WAIT, level: 1'b0, ms: MS_ALIVE_OFF};
         end
         PAT_LINK: begin
            if (pos == 2'd0) st = '{kind: KIND_WAIT, level: 1'b1, ms: MS_LINKUP};
         end
         default: begin
            st = '{kind: KIND_LOOP, level: 1'b0, ms: '0};
         end
      endcase
      return st;
   endfunction

   // Microcode
   typedef enum logic [3:0] {
      OP_IDLE,
      OP_SETPOS,
      OP_UPDATE,
      OP_EXEC_INIT,
      OP_EXEC,
      OP_RETURN,
      OP_RESPOND,
      OP_TICK,
      OP_NEXT_LED
   } uc_op_type;

   typedef logic [UC_ADDR_W-1:0] uc_addr_type;
   localparam uc_addr_type UC_IDLE      = 4'd0;
   localparam uc_addr_type UC_SETPOS    = 4'd1;
   localparam uc_addr_type UC_UPDATE    = 4'd2;
   localparam uc_addr_type UC_EXEC_INIT = 4'd3;
   localparam uc_addr_type UC_EXEC      = 4'd4;
   localparam uc_addr_type UC_RETURN    = 4'd5;
   localparam uc_addr_type UC_RESP      = 4'd6;
   localparam uc_addr_type UC_TICK      = 4'd7;
   localparam uc_addr_type UC_TICK_NEXT = 4'd8;

   // Condition true takes jump_addr, false takes next_addr
   typedef struct packed {
      uc_op_type   op;
      uc_addr_type next_addr;
      uc_addr_type jump_addr;
   } uc_word_type;

   function automatic uc_word_type uc_fetch(input uc_addr_type addr);
      uc_word_type w;
      case (addr)
         UC_IDLE:      w = '{op: OP_IDLE,      next_addr: UC_SETPOS,    jump_addr: UC_TICK};
         UC_SETPOS:    w = '{op: OP_SETPOS,    next_addr: UC_UPDATE,    jump_addr: UC_RESP};
         UC_UPDATE:    w = '{op: OP_UPDATE,    next_addr: UC_EXEC_INIT, jump_addr: UC_RESP};
         UC_EXEC_INIT: w = '{op: OP_EXEC_INIT, next_addr: UC_EXEC,      jump_addr: UC_RETURN};
         UC_EXEC:      w = '{op: OP_EXEC,      next_addr: UC_EXEC,      jump_addr: UC_RETURN};
         UC_RETURN:    w = '{op: OP_RETURN,    next_addr: UC_RESP,      jump_addr: UC_TICK_NEXT};
         UC_RESP:      w = '{op: OP_RESPOND,   next_addr: UC_IDLE,      jump_addr: UC_RESP};
         UC_TICK:      w = '{op: OP_TICK,      next_addr: UC_TICK_NEXT, jump_addr: UC_EXEC_INIT};
         UC_TICK_NEXT: w = '{op: OP_NEXT_LED,  next_addr: UC_TICK,      jump_addr: UC_RESP};
         default:      w = '{op: OP_IDLE,      next_addr: UC_IDLE,      jump_addr: UC_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

/* rtl/lpps_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface lpps_req_if;
   import lpps_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [LED_IDX_W-1:0]  led_index;
   logic [SEQ_IDX_W-1:0]  sequence_index;

   modport source (output valid, req_type, led_index, sequence_index, input ready);
   modport sink   (input valid, req_type, led_index, sequence_index, output ready);
endinterface

`default_nettype wire

/* rtl/lpps_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface lpps_rsp_if;
   import lpps_pkg::*;

   logic                valid;
   logic                ready;
   logic [LEVELS_W-1:0] led_levels;
   logic [ACTIVE_W-1:0] active_of_addressed;

   modport source (output valid, led_levels, active_of_addressed, input ready);
   modport sink   (input valid, led_levels, active_of_addressed, output ready);
endinterface

`default_nettype wire

/* rtl/led_priority_pattern_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none

// Priority LED blink sequencer. Each LED keeps a position in every blink sequence and
// is driven by its lowest-indexed running sequence. A transaction on req_chan is a 1 ms
// tick, a run request or a stop request; every transaction returns exactly one
// transaction on rsp_chan with the LED levels and the active sequence of the addressed
// LED (6 = none). A small microprogram walks the work one control word per cycle. The
// step walk executes one table step per cycle, at most MAX_STEPS_PER_ITEM per LED, and a
// walk that hits that bound resumes on the next tick; a tick also walks every LED.
// req_chan.ready is high only while the sequencer is idle; the response register lets
// the next transaction in while a response still waits.
// Registers on the csr_ port: 0 enable, 1 charging on time, 2 charging off time (ms).
module led_priority_pattern_sequencer #(
   parameter int LED_COUNT          = lpps_pkg::LED_COUNT_DEF,
   parameter int SEQUENCE_COUNT     = lpps_pkg::SEQUENCE_COUNT_DEF,
   parameter int MAX_STEPS_PER_ITEM = lpps_pkg::MAX_STEPS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   lpps_req_if.sink                            req_chan,
   lpps_rsp_if.source                          rsp_chan,
   input  wire logic                           csr_wr_en,
   input  wire logic [lpps_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lpps_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lpps_pkg::*;

   localparam int SEQ_USED = (SEQUENCE_COUNT < TABLE_SEQS) ? SEQUENCE_COUNT : TABLE_SEQS;
   localparam int LED_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int CNT_W    = $clog2(MAX_STEPS_PER_ITEM + 1);

   typedef logic [SEQ_USED-1:0][POS_W-1:0] row_type;

   // Microsequencer and latched transaction
   uc_addr_type           upc_ff, upc_in;
   uc_word_type           uc_word;
   logic [LED_W-1:0]      cur_led_ff, cur_led_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   req_code_type          req_type_ff, req_type_in;
   logic [LED_IDX_W-1:0]  addr_led_ff, addr_led_in;
   logic [SEQ_IDX_W-1:0]  seq_ff, seq_in;

   // Per-LED state
   logic [ACTIVE_W-1:0]   active_ff [LED_COUNT];
   logic [ACTIVE_W-1:0]   active_in [LED_COUNT];
   row_type               pos_ff [LED_COUNT];
   row_type               pos_in [LED_COUNT];
   logic [MS_W-1:0]       cnt_ff [LED_COUNT];
   logic [MS_W-1:0]       cnt_in [LED_COUNT];
   logic [LED_COUNT-1:0]  level_ff, level_in;

   // Registers
   logic                  enable_ff;
   logic [MS_W-1:0]       chg_on_ff;
   logic [MS_W-1:0]       chg_off_ff;

   // Response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEVELS_W-1:0]   levels_out_ff, levels_out_in;
   logic [ACTIVE_W-1:0]   active_out_ff, active_out_in;

   // Datapath helpers
   logic                  req_accept;
   logic                  rsp_busy;
   row_type               cur_row;
   logic [ACTIVE_W-1:0]   cur_active;
   logic [MS_W-1:0]       cur_cnt;
   logic [ACTIVE_W-1:0]   enc_active;
   logic [POS_W-1:0]      exec_pos;
   step_type              step;
   logic [MS_W-1:0]       step_ms;
   logic                  active_ok;
   logic                  led_ok;
   logic                  req_ok;
   logic [LED_COUNT+LEVELS_W-1:0] level_pad;

   assign uc_word    = uc_fetch(upc_ff);
   assign req_accept = req_chan.valid && req_chan.ready;
   assign rsp_busy   = rsp_valid_ff && !rsp_chan.ready;

   assign req_chan.ready               = (uc_word.op == OP_IDLE);
   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.led_levels          = levels_out_ff;
   assign rsp_chan.active_of_addressed = active_out_ff;

   assign cur_row    = pos_ff[cur_led_ff];
   assign cur_active = active_ff[cur_led_ff];
   assign cur_cnt    = cnt_ff[cur_led_ff];
   assign active_ok  = (32'(cur_active) < SEQ_USED);
   assign led_ok     = (32'(addr_led_ff) < LED_COUNT);
   assign req_ok     = ((req_type_ff == REQ_RUN) || (req_type_ff == REQ_STOP)) && led_ok &&
                       (32'(seq_ff) < SEQ_USED);
   assign level_pad  = {{LEVELS_W{1'b0}}, level_ff};

   // Priority encode the running sequences and pick the step of the active one
   always_comb begin
      enc_active = ACTIVE_NONE;
      for (int p = SEQ_USED - 1; p >= 0; p--) begin
         if (cur_row[p] != POS_STOPPED) enc_active = ACTIVE_W'(p);
      end
      exec_pos = POS_STOPPED;
      for (int p = 0; p < SEQ_USED; p++) begin
         if (cur_active == ACTIVE_W'(p)) exec_pos = cur_row[p];
      end
      step = step_lookup(cur_active, exec_pos);
      case (step.kind)
         KIND_CHG_ON:  step_ms = chg_on_ff;
         KIND_CHG_OFF: step_ms = chg_off_ff;
         default:      step_ms = step.ms;
      endcase
   end

   // Datapath controlled by the current control word
   always_comb begin
      upc_in        = upc_ff;
      cur_led_in    = cur_led_ff;
      count_in      = count_ff;
      req_type_in   = req_type_ff;
      addr_led_in   = addr_led_ff;
      seq_in        = seq_ff;
      active_in     = active_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      level_in      = level_ff;
      rsp_valid_in  = rsp_busy;
      levels_out_in = levels_out_ff;
      active_out_in = active_out_ff;

      case (uc_word.op)
         OP_IDLE: begin
            // take the transaction; a tick walks every LED from LED 0
            if (req_accept) begin
               req_type_in = req_chan.req_type;
               addr_led_in = req_chan.led_index;
               seq_in      = req_chan.sequence_index;
               if (req_chan.req_type == REQ_TICK) begin
                  cur_led_in = '0;
                  upc_in     = uc_word.jump_addr;
               end else begin
                  cur_led_in = LED_W'(req_chan.led_index);
                  upc_in     = uc_word.next_addr;
               end
            end
         end
         OP_SETPOS: begin
            // start or stop the addressed pair; drop malformed requests
            if (req_ok) begin
               for (int p = 0; p < SEQ_USED; p++) begin
                  if (seq_ff == SEQ_IDX_W'(p))
                     pos_in[cur_led_ff][p] = (req_type_ff == REQ_RUN) ? '0 : POS_STOPPED;
               end
               upc_in = uc_word.next_addr;
            end else begin
               upc_in = uc_word.jump_addr;
            end
         end
         OP_UPDATE: begin
            // recompute the active sequence and turn the LED off
            active_in[cur_led_ff] = enc_active;
            level_in[cur_led_ff]  = 1'b0;
            if ((req_type_ff == REQ_RUN) && (enc_active != seq_ff))
               upc_in = uc_word.jump_addr;
            else
               upc_in = uc_word.next_addr;
         end
         OP_EXEC_INIT: begin
            count_in = '0;
            upc_in   = enable_ff ? uc_word.next_addr : uc_word.jump_addr;
         end
         OP_EXEC: begin
            // one table step per cycle
            if (!active_ok) begin
               upc_in = uc_word.jump_addr;
            end else if (count_ff >= CNT_W'(MAX_STEPS_PER_ITEM)) begin
               // step bound hit: resume on the next tick
               cnt_in[cur_led_ff] = MS_W'(1);
               upc_in             = uc_word.jump_addr;
            end else begin
               count_in = count_ff + CNT_W'(1);
               upc_in   = uc_word.next_addr;
               for (int p = 0; p < SEQ_USED; p++) begin
                  if (cur_active == ACTIVE_W'(p)) begin
                     if (step.kind == KIND_LOOP) pos_in[cur_led_ff][p] = '0;
                     else pos_in[cur_led_ff][p] = exec_pos + POS_W'(1);
                  end
               end
               if (step.kind != KIND_LOOP) begin
                  level_in[cur_led_ff] = step.level;
                  if (step_ms != '0) begin
                     cnt_in[cur_led_ff] = step_ms;
                     upc_in             = uc_word.jump_addr;
                  end
               end
            end
         end
         OP_RETURN: begin
            upc_in = (req_type_ff == REQ_TICK) ? uc_word.jump_addr : uc_word.next_addr;
         end
         OP_TICK: begin
            // count the wait down; expiry runs the steps of this LED
            upc_in = uc_word.next_addr;
            if (cur_cnt != '0) begin
               cnt_in[cur_led_ff] = cur_cnt - MS_W'(1);
               if (cur_cnt == MS_W'(1)) upc_in = uc_word.jump_addr;
            end
         end
         OP_NEXT_LED: begin
            // advance the LED walk; at its end point back at the addressed LED
            if (32'(cur_led_ff) == LED_COUNT - 1) begin
               cur_led_in = LED_W'(addr_led_ff);
               upc_in     = uc_word.jump_addr;
            end else begin
               cur_led_in = cur_led_ff + LED_W'(1);
               upc_in     = uc_word.next_addr;
            end
         end
         OP_RESPOND: begin
            // hold while the previous response is still waiting
            if (rsp_busy) begin
               upc_in = uc_word.jump_addr;
            end else begin
               rsp_valid_in  = 1'b1;
               levels_out_in = level_pad[LEVELS_W-1:0];
               active_out_in = led_ok ? cur_active : ACTIVE_NONE;
               upc_in        = uc_word.next_addr;
            end
         end
         default: begin
            upc_in = UC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= UC_IDLE;
         count_ff     <= '0;
         cur_led_ff   <= '0;
         req_type_ff  <= REQ_TICK;
         addr_led_ff  <= '0;
         seq_ff       <= '0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         enable_ff    <= ENABLE_RST;
         chg_on_ff    <= CHG_ON_RST;
         chg_off_ff   <= CHG_OFF_RST;
         for (int i = 0; i < LED_COUNT; i++) begin
            active_ff[i] <= ACTIVE_NONE;
            pos_ff[i]    <= {SEQ_USED{POS_STOPPED}};
            cnt_ff[i]    <= '0;
         end
      end else begin
         upc_ff       <= upc_in;
         count_ff     <= count_in;
         cur_led_ff   <= cur_led_in;
         req_type_ff  <= req_type_in;
         addr_led_ff  <= addr_led_in;
         seq_ff       <= seq_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ENABLE:  enable_ff  <= csr_wdata[0];
               CSR_CHG_ON:  chg_on_ff  <= csr_wdata;
               CSR_CHG_OFF: chg_off_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      levels_out_ff <= levels_out_in;
      active_out_ff <= active_out_in;
   end

endmodule

`default_nettype wire

/* tb/sv/lpps_blink_checker.sv */
`timescale 1ns / 1ps

// Watch the request, response and register ports, predict every response and
// compare it field by field against the oldest outstanding prediction.
module lpps_blink_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   lpps_req_if                                  req_mon,
   lpps_rsp_if                                  rsp_mon,
   input  wire logic                            csr_wr_en,
   input  wire logic [lpps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lpps_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                                   fail_count,
   output int                                   backlog,
   output int                                   checked
);
   import lpps_pkg::*;

   localparam int LEDS     = LED_COUNT_DEF;
   localparam int STEP_CAP = MAX_STEPS_DEF;

   typedef struct packed {
      logic [LEVELS_W-1:0] levels;
      logic [ACTIVE_W-1:0] active;
   } led_report_type;

   logic            blink_en;
   logic [MS_W-1:0] chg_on_ms;
   logic [MS_W-1:0] chg_off_ms;

   logic [ACTIVE_W-1:0] active_seq [LEDS];
   logic [POS_W-1:0]    seq_pos    [LEDS][TABLE_SEQS];
   logic [MS_W-1:0]     countdown  [LEDS];
   logic                lit        [LEDS];

   led_report_type report_q[$];
   led_report_type want;

   function automatic void clear_state();
      blink_en   = ENABLE_RST;
      chg_on_ms  = CHG_ON_RST;
      chg_off_ms = CHG_OFF_RST;
      for (int i = 0; i < LEDS; i++) begin
         active_seq[i] = ACTIVE_NONE;
         countdown[i]  = '0;
         lit[i]        = 1'b0;
         for (int j = 0; j < TABLE_SEQS; j++) seq_pos[i][j] = POS_STOPPED;
      end
   endfunction

   // Drop the LED and hand it to its lowest running sequence
   function automatic void pick_active(int led);
      lit[led]        = 1'b0;
      active_seq[led] = ACTIVE_NONE;
      for (int s = TABLE_SEQS - 1; s >= 0; s--) begin
         if (seq_pos[led][s] != POS_STOPPED) active_seq[led] = ACTIVE_W'(s);
      end
   endfunction

   function automatic void walk_steps(int led);
      int              n;
      int              s;
      logic [POS_W-1:0] at;
      step_kind_type   k;
      logic            lvl;
      logic [MS_W-1:0] ms;
      bit              running;
      if (!blink_en) return;
      n       = 0;
      running = 1'b1;
      while (running) begin
         s = int'(active_seq[led]);
         if (s >= TABLE_SEQS) begin
            running = 1'b0;
         end else if (n >= STEP_CAP) begin
            countdown[led] = 16'd1;
            running        = 1'b0;
         end else begin
            n++;
            at = seq_pos[led][s];
            if (at == POS_STOPPED) begin
               pick_active(led);
            end else begin
               k   = KIND_LOOP;
               lvl = 1'b0;
               ms  = '0;
               case (seq_code_type'(s))
                  PAT_CHARGE: begin
                     if (at == 2'd0) begin
                        k   = KIND_CHG_ON;
                        lvl = 1'b1;
                     end else if (at == 2'd1) begin
                        k = KIND_CHG_OFF;
                     end
                  end
                  PAT_HEARTBEAT: begin
                     if (at == 2'd0) begin
                        k   = KIND_WAIT;
                        lvl = 1'b1;
                        ms  = MS_ALIVE_ON;
                     end else if (at == 2'd1) begin
                        k  = KIND_WAIT;
                        ms = MS_ALIVE_OFF;
                     end
                  end
                  PAT_LINK: begin
                     if (at == 2'd0) begin
                        k   = KIND_WAIT;
                        lvl = 1'b1;
                        ms  = MS_LINKUP;
                     end
                  end
                  default: begin
                     if (at == 2'd0) begin
                        k   = KIND_WAIT;
                        lvl = 1'b1;
                        ms  = MS_STEADY;
                     end
                  end
               endcase
               if (k == KIND_LOOP) begin
                  seq_pos[led][s] = '0;
               end else begin
                  seq_pos[led][s] = at + 1'b1;
                  lit[led]        = lvl;
                  if (k == KIND_CHG_ON) ms = chg_on_ms;
                  else if (k == KIND_CHG_OFF) ms = chg_off_ms;
                  if (ms != '0) begin
                     countdown[led] = ms;
                     running        = 1'b0;
                  end
               end
            end
         end
      end
   endfunction

   function automatic led_report_type predict_report(logic [REQ_TYPE_W-1:0] kind,
                                                     logic [LED_IDX_W-1:0] led,
                                                     logic [SEQ_IDX_W-1:0] seq);
      led_report_type r;
      int             l;
      l = int'(led);
      if (kind == REQ_TICK) begin
         for (int i = 0; i < LEDS; i++) begin
            if (countdown[i] != '0) begin
               countdown[i] = countdown[i] - 1'b1;
               if (countdown[i] == '0) walk_steps(i);
            end
         end
      end else if ((kind == REQ_RUN || kind == REQ_STOP) && l < LEDS &&
                   int'(seq) < TABLE_SEQS) begin
         if (kind == REQ_RUN) begin
            seq_pos[l][seq] = '0;
            pick_active(l);
            if (active_seq[l] == seq) walk_steps(l);
         end else begin
            seq_pos[l][seq] = POS_STOPPED;
            pick_active(l);
            walk_steps(l);
         end
      end
      r.levels = '0;
      for (int i = 0; i < LEDS && i < LEVELS_W; i++) r.levels[i] = lit[i];
      r.active = (l < LEDS) ? active_seq[l] : ACTIVE_NONE;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         report_q.delete();
         fail_count = 0;
         checked    = 0;
         backlog    = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ENABLE:  blink_en   = csr_wdata[0];
               CSR_CHG_ON:  chg_on_ms  = csr_wdata[MS_W-1:0];
               CSR_CHG_OFF: chg_off_ms = csr_wdata[MS_W-1:0];
               default: ;
            endcase
         end
         // Responses belong to earlier requests, so retire before predicting
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (report_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response levels=%h active=%0d", $time,
                        rsp_mon.led_levels, rsp_mon.active_of_addressed);
            end else begin
               want = report_q.pop_front();
               checked++;
               if (rsp_mon.led_levels !== want.levels) begin
                  fail_count++;
                  $display("%0t: led_levels expected %h actual %h", $time,
                           want.levels, rsp_mon.led_levels);
               end
               if (rsp_mon.active_of_addressed !== want.active) begin
                  fail_count++;
                  $display("%0t: active_of_addressed expected %0d actual %0d", $time,
                           want.active, rsp_mon.active_of_addressed);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            report_q.push_back(predict_report(req_mon.req_type, req_mon.led_index,
                                              req_mon.sequence_index));
         end
         backlog = report_q.size();
      end
   end

endmodule

/* tb/sv/led_priority_pattern_sequencer_tb.sv */
`timescale 1ns / 1ps

// Top of the sequencer bench: clock, reset, stimulus and verdict. The checker
// beside the block does all prediction and comparison and reports back a
// failure count and how many responses are still outstanding.
module led_priority_pattern_sequencer_tb;
   import lpps_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   // Covers the worst tick: the LED walk plus an expiry and step walk on every LED
   localparam int SETTLE_CYCLES = 60;
   localparam int PHASE_ITEMS   = 20;
   localparam int SOAK_ITEMS    = 250;

   // Codes outside the legal ranges, used to hit the ignore paths
   localparam req_code_type REQ_UNKNOWN    = 2'd3;
   localparam seq_code_type SEQ_PAST_TABLE = 3'd6;
   localparam seq_code_type SEQ_TOP_CODE   = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lpps_req_if req_chan ();
   lpps_rsp_if rsp_chan ();

   int fail_count;
   int backlog;
   int checked;
   int cycle_count = 0;

   // Per-phase switches that turn off idling on one side
   bit tx_steady = 1'b0;
   bit rx_steady = 1'b0;

   int sent_ticks    = 0;
   int sent_runs     = 0;
   int sent_stops    = 0;
   int sent_other    = 0;
   int settings_used = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   led_priority_pattern_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lpps_blink_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .backlog    (backlog),
      .checked    (checked)
   );

   // Guard against a hung handshake
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding", cycle_count,
                  backlog);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Response side: stall at random before taking each transaction, unless rx_steady is set
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = rx_steady ? 0 : $urandom_range(0, 3);
         repeat (stall) begin
            rsp_chan.ready = 1'b0;
            @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Present one request after a random gap and hold it until accepted.
   // Valid stays high into the next call, so back-to-back requests need no gap.
   task automatic send_item(input req_code_type kind, input logic [LED_IDX_W-1:0] led,
                            input seq_code_type seq);
      int gap;
      gap = tx_steady ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      repeat (gap) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.req_type       = kind;
      req_chan.led_index      = led;
      req_chan.sequence_index = seq;
      req_chan.valid          = 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (kind == REQ_TICK) sent_ticks++;
      else if (kind == REQ_RUN && int'(seq) < TABLE_SEQS) sent_runs++;
      else if (kind == REQ_STOP && int'(seq) < TABLE_SEQS) sent_stops++;
      else sent_other++;
   endtask

   // Drop valid and wait until every response has come back
   task automatic settle_idle();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (backlog != 0) @(negedge clock);
   endtask

   task automatic write_reg(input csr_addr_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic apply_setting(input logic en, input logic [MS_W-1:0] on_ms,
                                input logic [MS_W-1:0] off_ms);
      settle_idle();
      write_reg(CSR_ENABLE, {{(CSR_DATA_W-1){1'b0}}, en});
      write_reg(CSR_CHG_ON, on_ms);
      write_reg(CSR_CHG_OFF, off_ms);
      settings_used++;
   endtask

   // Mostly ticks so waits expire; runs and stops on random LEDs, with the odd
   // out-of-range sequence or unknown request type mixed in
   task automatic random_item(input int tick_pct);
      int           roll;
      logic [1:0]   led;
      seq_code_type seq;
      roll = $urandom_range(0, 99);
      led  = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 99) < 6) seq = seq_code_type'($urandom_range(6, 7));
      else seq = seq_code_type'($urandom_range(0, 5));
      if (roll < tick_pct) send_item(REQ_TICK, led, seq);
      else if (roll < tick_pct + (100 - tick_pct) / 2) send_item(REQ_RUN, led, seq);
      else if (roll < 97) send_item(REQ_STOP, led, seq);
      else send_item(REQ_UNKNOWN, led, seq);
   endtask

   task automatic random_phase(input logic en, input logic [MS_W-1:0] on_ms,
                               input logic [MS_W-1:0] off_ms, input int items,
                               input int tick_pct);
      apply_setting(en, on_ms, off_ms);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      repeat (items) random_item(tick_pct);
   endtask

   initial begin
      reset                   = 1'b1;
      csr_wr_en               = 1'b0;
      csr_index               = CSR_ENABLE;
      csr_wdata               = '0;
      req_chan.valid          = 1'b0;
      req_chan.req_type       = REQ_TICK;
      req_chan.led_index      = '0;
      req_chan.sequence_index = PAT_BATT_LOW;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: tick with nothing running, priority take-over and release
      send_item(REQ_TICK, 2'd0, PAT_BATT_LOW);
      send_item(REQ_RUN, 2'd0, PAT_LINK);
      send_item(REQ_RUN, 2'd0, PAT_HEARTBEAT);
      // Lower priority start: LED goes dark, no steps, pending wait kept
      send_item(REQ_RUN, 2'd0, PAT_LINK);
      send_item(REQ_RUN, 2'd3, PAT_BATT_LOW);
      send_item(REQ_STOP, 2'd0, PAT_HEARTBEAT);
      // Ignored requests: sequence past the table, unknown request type
      send_item(REQ_STOP, 2'd0, SEQ_PAST_TABLE);
      send_item(REQ_RUN, 2'd1, SEQ_TOP_CODE);
      send_item(REQ_UNKNOWN, 2'd2, PAT_CAL_DONE);
      // Stop with nothing running on the LED
      send_item(REQ_STOP, 2'd2, PAT_CHARGE);
      send_item(REQ_RUN, 2'd2, PAT_FULL);
      send_item(REQ_RUN, 2'd1, PAT_CAL_DONE);
      send_item(REQ_RUN, 2'd2, PAT_CHARGE);

      // Disabled: positions move, nothing executes
      apply_setting(1'b0, CHG_ON_RST, CHG_OFF_RST);
      send_item(REQ_RUN, 2'd1, PAT_BATT_LOW);
      send_item(REQ_TICK, 2'd3, PAT_LINK);
      send_item(REQ_STOP, 2'd3, PAT_BATT_LOW);

      // Zero charging times loop until the step bound, then resume per tick
      apply_setting(1'b1, 16'd0, 16'd0);
      send_item(REQ_STOP, 2'd2, PAT_FULL);
      send_item(REQ_TICK, 2'd2, PAT_CHARGE);
      send_item(REQ_TICK, 2'd2, PAT_CHARGE);

      // Short charging blink, alive on another LED
      apply_setting(1'b1, 16'd1, 16'd2);
      send_item(REQ_RUN, 2'd3, PAT_HEARTBEAT);
      repeat (5) send_item(REQ_TICK, 2'd3, PAT_HEARTBEAT);

      // Soak, nearly all ticks, so the short blink waits expire many times
      random_phase(1'b1, 16'd3, 16'd1, SOAK_ITEMS, 98);

      random_phase(1'b1, 16'd0, 16'd4, PHASE_ITEMS, 70);
      random_phase(1'b0, 16'd2, 16'd2, PHASE_ITEMS, 70);
      random_phase(1'b1, 16'hFFFF, 16'd0, PHASE_ITEMS, 70);
      random_phase(1'b1, 16'd0, 16'hFFFF, PHASE_ITEMS, 70);
      random_phase(1'b1, 16'd1, 16'd0, PHASE_ITEMS, 70);
      random_phase(1'b1, MS_W'($urandom_range(0, 5)), MS_W'($urandom_range(0, 5)),
                   PHASE_ITEMS, 70);

      // Back to the reset values, then let the last responses drain
      apply_setting(ENABLE_RST, CHG_ON_RST, CHG_OFF_RST);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d transactions: %0d ticks, %0d runs, %0d stops, %0d ignored",
               sent_ticks + sent_runs + sent_stops + sent_other, sent_ticks, sent_runs,
               sent_stops, sent_other);
      $display("Checked %0d responses over %0d register settings, %0d mismatches",
               checked, settings_used, fail_count);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* led_priority_pattern_sequencer.f */
rtl/lpps_pkg.sv
rtl/lpps_req_if.sv
rtl/lpps_rsp_if.sv
rtl/led_priority_pattern_sequencer.sv
tb/sv/lpps_blink_checker.sv
tb/sv/led_priority_pattern_sequencer_tb.sv
